// File: rtl/core/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
package bdq_pkg;

    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_BACK  = 3'd3,
        REQ_CLEAR     = 3'd4,
        REQ_READ      = 3'd5
    } t_req;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_POP_FRONT,
        CELL_PUSH_BACK,
        CELL_ROTATE
    } t_cell_op;

    // Chain control: operation and the cell position it targets at the tail
    typedef struct packed {
        t_cell_op            op;
        logic [COUNT_W-1:0]  tail;
    } t_cell_ctl;

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } t_state;

endpackage

// File: rtl/core/bdq_cell.sv
// One storage cell of the queue chain; takes a word from a neighbor, the input or the front cell, or keeps its own.
module bdq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  bdq_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_head,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  at_tail;

    assign at_tail = (bdq_pkg::COUNT_W'(INDEX) == i_ctl.tail);

    // Pick the next word for this cell
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            bdq_pkg::CELL_HOLD:       n_data = r_data;
            bdq_pkg::CELL_PUSH_FRONT: n_data = i_left;
            bdq_pkg::CELL_POP_FRONT:  n_data = i_right;
            bdq_pkg::CELL_PUSH_BACK:  n_data = at_tail ? i_value : r_data;
            bdq_pkg::CELL_ROTATE:     n_data = at_tail ? i_head : i_right;
            default:                  n_data = r_data;
        endcase
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue built as a shifting chain of cells.
//
// The store is a row of DEPTH cells; cell 0 always holds the front element.
// Front inserts and removals shift the whole row by one cell, back inserts write
// the cell just past the last element. Every request but a read-out is accepted
// while busy is low, and its single result appears on the next cycle with o_valid
// high. A read-out of n stored elements keeps busy high while the chain rotates
// its first n cells by one each cycle, handing the front word to the output
// register; results come one per cycle, front first, with o_last on the final
// one, and the row is back in its original order when busy falls. The next request
// may be started in the cycle the last word is shown. Results cannot be stalled
// by the receiver. Capacity is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while idle; the block does not enforce it. The effective limit is min(capacity, DEPTH).
module bounded_double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [bdq_pkg::REQ_W-1:0]      i_req_type,
    input  logic [bdq_pkg::FIELD_W-1:0]    i_value,
    output logic                           o_valid,
    output logic [bdq_pkg::STATUS_W-1:0]   o_status,
    output logic [bdq_pkg::FIELD_W-1:0]    o_element,
    output logic                           o_last,
    output logic [bdq_pkg::COUNT_W-1:0]    o_count
);

    localparam int CW = bdq_pkg::COUNT_W;

    bdq_pkg::t_state              r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_rd_left, n_rd_left;
    logic [bdq_pkg::CAP_W-1:0]    r_cap;
    logic                         r_valid, n_valid;
    bdq_pkg::t_status             r_status, n_status;
    logic [bdq_pkg::FIELD_W-1:0]  r_element, n_element;
    logic                         r_last, n_last;
    logic [CW-1:0]                r_out_count, n_out_count;

    bdq_pkg::t_cell_ctl           cell_ctl;
    logic [DATA_WIDTH-1:0]        value_word;
    logic [DATA_WIDTH-1:0]        cell_data [DEPTH];
    logic [CW-1:0]                cap_eff;
    logic                         full;
    logic                         empty;

    assign value_word = DATA_WIDTH'(i_value);
    assign cap_eff    = (r_cap < CW'(DEPTH)) ? r_cap : CW'(DEPTH);
    assign full       = (r_count >= cap_eff);
    assign empty      = (r_count == '0);

    // Build the cell chain; cell 0 is the front
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_word;
        logic [DATA_WIDTH-1:0] right_word;

        if (g == 0) begin : g_first
            assign left_word = value_word;
        end else begin : g_mid_l
            assign left_word = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_word = cell_data[g];
        end else begin : g_mid_r
            assign right_word = cell_data[g+1];
        end

        bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_value (value_word),
            .i_left  (left_word),
            .i_right (right_word),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[g])
        );
    end

    // Next state, chain control and result word
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rd_left     = r_rd_left;
        n_valid       = 1'b0;
        n_status      = r_status;
        n_element     = r_element;
        n_last        = r_last;
        n_out_count   = r_out_count;
        cell_ctl.op   = bdq_pkg::CELL_HOLD;
        cell_ctl.tail = r_count;
        unique case (r_state)
            bdq_pkg::FSM_IDLE: begin
                if (start) begin
                    n_valid   = 1'b1;
                    n_status  = bdq_pkg::STAT_DONE;
                    n_element = '0;
                    n_last    = 1'b1;
                    unique case (bdq_pkg::t_req'(i_req_type))
                        bdq_pkg::REQ_INS_FRONT: begin
                            if (full) begin
                                n_status = bdq_pkg::STAT_FULL;
                            end else begin
                                cell_ctl.op = bdq_pkg::CELL_PUSH_FRONT;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        bdq_pkg::REQ_INS_BACK: begin
                            if (full) begin
                                n_status = bdq_pkg::STAT_FULL;
                            end else begin
                                cell_ctl.op = bdq_pkg::CELL_PUSH_BACK;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        bdq_pkg::REQ_REM_FRONT: begin
                            if (empty) begin
                                n_status = bdq_pkg::STAT_EMPTY;
                            end else begin
                                cell_ctl.op = bdq_pkg::CELL_POP_FRONT;
                                n_count     = r_count - CW'(1);
                            end
                        end
                        bdq_pkg::REQ_REM_BACK: begin
                            if (empty) begin
                                n_status = bdq_pkg::STAT_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        bdq_pkg::REQ_CLEAR: begin
                            n_count = '0;
                        end
                        bdq_pkg::REQ_READ: begin
                            if (empty) begin
                                n_status = bdq_pkg::STAT_EMPTY;
                            end else begin
                                n_valid   = 1'b0;
                                n_state   = bdq_pkg::FSM_READ;
                                n_rd_left = r_count;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = n_count;
                end
            end
            bdq_pkg::FSM_READ: begin
                // Rotate the occupied cells, send the front word out
                cell_ctl.op   = bdq_pkg::CELL_ROTATE;
                cell_ctl.tail = r_count - CW'(1);
                n_valid       = 1'b1;
                n_status      = bdq_pkg::STAT_DONE;
                n_element     = bdq_pkg::FIELD_W'(cell_data[0]);
                n_last        = (r_rd_left == CW'(1));
                n_out_count   = r_count;
                n_rd_left     = r_rd_left - CW'(1);
                if (r_rd_left == CW'(1)) begin
                    n_state = bdq_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = bdq_pkg::FSM_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::FSM_IDLE;
            r_count <= '0;
            r_cap   <= bdq_pkg::CAP_W'(64);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Result word and read-out counter
    always_ff @(posedge i_clk) begin
        r_rd_left   <= n_rd_left;
        r_status    <= n_status;
        r_element   <= n_element;
        r_last      <= n_last;
        r_out_count <= n_out_count;
    end

    assign busy      = (r_state == bdq_pkg::FSM_READ);
    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_last    = r_last;
    assign o_count   = r_out_count;

    // The stored count never passes the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond depth");

    // Every read-out cycle produces a word
    a_read_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bdq_pkg::FSM_READ) |=> o_valid)
        else $error("read-out cycle without a result");

    // Leaving read-out shows the final word
    a_read_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_last))
        else $error("read-out ended without last word");

    // A refused insert keeps the count and reports full
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && full &&
         (i_req_type == bdq_pkg::REQ_INS_FRONT || i_req_type == bdq_pkg::REQ_INS_BACK))
        |=> (o_status == bdq_pkg::STAT_FULL && $stable(r_count)))
        else $error("insert into full store not refused");

endmodule
